### rtl/slicpa_pkg.sv
package slicpa_pkg;

   // Default image geometry and cluster count.
   localparam int ImageWidthDef  = 1024;
   localparam int ImageHeightDef = 512;
   localparam int MaxClustersDef = 4096;

   // Field widths of the request and response.
   localparam int IDX_W   = 12;
   localparam int LAB_C_W = 12;
   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int PIX_W   = 8;
   localparam int LABEL_W = 16;
   localparam int DIST_W  = 32;
   localparam int CMP_W   = 8;

   // Values of an empty entry and the reset compactness.
   localparam logic [DIST_W-1:0]  EMPTY_DIST    = 32'hFFFF_FFFF;
   localparam logic [LABEL_W-1:0] EMPTY_LABEL   = 16'd65534;
   localparam logic [CMP_W-1:0]   COMPACT_RESET = 8'd10;

   // Register port geometry.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register index, taken from the word address bit of the register port.
   typedef enum logic [0:0] {
      CSR_COMPACTNESS = 1'b0
   } csr_reg_type;

   // Division by constants as multiplication by a reciprocal.
   // The colour term divides by 100 as a shift by two and a division by 25;
   // the spatial term 2304/10 is 230 plus 2/5.
   localparam logic [27:0] COLOUR_RECIP = 28'd171798691; // floor(2^32 / 25)
   localparam logic [19:0] SPACE_RECIP  = 20'd838860;    // floor(2^22 / 5)
   localparam int          COLOUR_DIV   = 25;
   localparam int          SPACE_DIV    = 5;
   localparam int          SPACE_WHOLE  = 230;

   // One request: a pixel paired with a cluster centre.
   typedef struct packed {
      logic [IDX_W-1:0]   cluster_index;
      logic [LAB_C_W-1:0] center_l;
      logic [LAB_C_W-1:0] center_a;
      logic [LAB_C_W-1:0] center_b;
      logic [X_W-1:0]     center_x;
      logic [Y_W-1:0]     center_y;
      logic [X_W-1:0]     pixel_x;
      logic [Y_W-1:0]     pixel_y;
      logic [PIX_W-1:0]   pixel_l;
      logic [PIX_W-1:0]   pixel_a;
      logic [PIX_W-1:0]   pixel_b;
      logic               new_frame;
   } req_type;

   // One response: the pixel's assignment after the request.
   typedef struct packed {
      logic [X_W-1:0]     out_x;
      logic [Y_W-1:0]     out_y;
      logic [LABEL_W-1:0] label;
      logic [DIST_W-1:0]  distance;
      logic               taken;
   } rsp_type;

endpackage

### rtl/slic_pixel_assignment_core.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_data (req_type)
// rsp_      out        rsp_valid / rsp_stall   rsp_data (rsp_type)
// csr_      in/out     csr_psel / csr_penable  csr_paddr, csr_pwdata, csr_prdata
//
// One request is taken in every cycle while req_stall is low; a response leaves
// through the eight arithmetic stages and the output register after its request.
// After reset the block sweeps the label and distance memory, one entry per
// cycle, over all IMAGE_WIDTH * IMAGE_HEIGHT entries (524288 by default) with
// req_stall high; register writes are taken throughout.
// A stalled response fills one skid entry, after which the pipeline holds and
// req_stall rises; req_stall comes straight from registers.
module slic_pixel_assignment_core
   import slicpa_pkg::*;
#(
   parameter int IMAGE_WIDTH  = ImageWidthDef,
   parameter int IMAGE_HEIGHT = ImageHeightDef,
   parameter int MAX_CLUSTERS = MaxClustersDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int PixCount = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int AddrW    = $clog2(PixCount);
   localparam int MemW     = DIST_W + LABEL_W;

   // Per-request bookkeeping carried alongside the arithmetic.
   typedef struct packed {
      logic [AddrW-1:0] addr;
      logic             in_img;
      logic             idx_ok;
      logic             fresh;
      logic [IDX_W-1:0] idx;
      logic [X_W-1:0]   px;
      logic [Y_W-1:0]   py;
   } tag_type;

   logic             en;
   logic             accept;
   logic             skid_valid_ff;
   logic             out_valid_ff;
   logic             clearing_ff;
   logic [AddrW-1:0] clear_cnt_ff;
   logic [CMP_W-1:0] compact_ff;

   // Register port.
   csr_reg_type csr_sel;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_AW-1]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_sel == CSR_COMPACTNESS) ? CSR_DW'(compact_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff <= COMPACT_RESET;
      end else if (csr_wr && csr_sel == CSR_COMPACTNESS) begin
         compact_ff <= csr_pwdata[CMP_W-1:0];
      end
   end

   // The pipeline advances whenever the skid entry is free.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff || clearing_ff;
   assign accept    = req_valid && !req_stall;

   // Stage 1: colour and position differences, pixel address, range checks.
   logic signed [12:0] dl_in, da_in, db_in;
   logic signed [10:0] dx_in;
   logic signed [9:0]  dy_in;
   logic [31:0]        lin_addr;
   tag_type            tag_in;

   assign dl_in = $signed({1'b0, req_data.pixel_l, 4'b0000}) - $signed({1'b0, req_data.center_l});
   assign da_in = $signed({1'b0, req_data.pixel_a, 4'b0000}) - $signed({1'b0, req_data.center_a});
   assign db_in = $signed({1'b0, req_data.pixel_b, 4'b0000}) - $signed({1'b0, req_data.center_b});
   assign dx_in = $signed({1'b0, req_data.pixel_x}) - $signed({1'b0, req_data.center_x});
   assign dy_in = $signed({1'b0, req_data.pixel_y}) - $signed({1'b0, req_data.center_y});
   assign lin_addr = 32'(req_data.pixel_y) * 32'(IMAGE_WIDTH) + 32'(req_data.pixel_x);

   always_comb begin
      tag_in.addr   = lin_addr[AddrW-1:0];
      tag_in.in_img = (32'(req_data.pixel_x) < 32'(IMAGE_WIDTH)) &&
                      (32'(req_data.pixel_y) < 32'(IMAGE_HEIGHT));
      tag_in.idx_ok = 32'(req_data.cluster_index) < 32'(MAX_CLUSTERS);
      tag_in.fresh  = req_data.new_frame;
      tag_in.idx    = req_data.cluster_index;
      tag_in.px     = req_data.pixel_x;
      tag_in.py     = req_data.pixel_y;
   end

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic               s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   tag_type            s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   tag_type            s5_tag_ff, s6_tag_ff, s7_tag_ff, s8_tag_ff;
   logic signed [12:0] s1_dl_ff, s1_da_ff, s1_db_ff;
   logic signed [10:0] s1_dx_ff;
   logic signed [9:0]  s1_dy_ff;

   // Stage 2: squares.
   logic signed [25:0] sql_in, sqa_in, sqb_in;
   logic signed [21:0] sqx_in;
   logic signed [19:0] sqy_in;
   logic [23:0]        s2_sql_ff, s2_sqa_ff, s2_sqb_ff;
   logic [19:0]        s2_sqx_ff;
   logic [17:0]        s2_sqy_ff;

   assign sql_in = s1_dl_ff * s1_dl_ff;
   assign sqa_in = s1_da_ff * s1_da_ff;
   assign sqb_in = s1_db_ff * s1_db_ff;
   assign sqx_in = s1_dx_ff * s1_dx_ff;
   assign sqy_in = s1_dy_ff * s1_dy_ff;

   // Stage 3: colour and spatial sums.
   logic [25:0] s3_colour_ff;
   logic [20:0] s3_space_ff;

   // Stage 4: colour weighted by compactness.
   logic [33:0] s4_cm_ff;
   logic [20:0] s4_space_ff;

   // Stage 5: reciprocal partial products.
   logic [31:0] y_in;
   logic [21:0] w_in;
   logic [31:0] s5_y_ff;
   logic [21:0] s5_w_ff;
   logic [43:0] s5_ph_ff, s5_pl_ff;
   logic [41:0] s5_ps_ff;
   logic [28:0] s5_sp230_ff;

   assign y_in = s4_cm_ff[33:2];
   assign w_in = {s4_space_ff, 1'b0};

   // Stage 6: estimated quotients, at most one below the true value.
   logic [59:0] qsum_in;
   logic [31:0] s6_y_ff;
   logic [21:0] s6_w_ff;
   logic [27:0] s6_qc_ff;
   logic [19:0] s6_qs_ff;
   logic [28:0] s6_sp230_ff;

   assign qsum_in = (60'(s5_ph_ff) << 16) + 60'(s5_pl_ff);

   // Stage 7: quotient correction gives the colour and spatial terms.
   logic [31:0] rc_in;
   logic [21:0] rs_in;
   logic [27:0] ct_in;
   logic [28:0] st_in;
   logic [27:0] s7_ct_ff;
   logic [28:0] s7_st_ff;

   assign rc_in = s6_y_ff - 32'(32'(s6_qc_ff) * 32'(COLOUR_DIV));
   assign ct_in = s6_qc_ff + 28'(rc_in >= 32'(COLOUR_DIV));
   assign rs_in = s6_w_ff - 22'(32'(s6_qs_ff) * 32'(SPACE_DIV));
   assign st_in = s6_sp230_ff + 29'(s6_qs_ff) + 29'(rs_in >= 22'(SPACE_DIV));

   // Stage 8: total distance, which stays below 2^30 and never saturates;
   // the stored entry is read alongside.
   logic [29:0] s8_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff    <= tag_in;
         s1_dl_ff     <= dl_in;
         s1_da_ff     <= da_in;
         s1_db_ff     <= db_in;
         s1_dx_ff     <= dx_in;
         s1_dy_ff     <= dy_in;
         s2_tag_ff    <= s1_tag_ff;
         s2_sql_ff    <= sql_in[23:0];
         s2_sqa_ff    <= sqa_in[23:0];
         s2_sqb_ff    <= sqb_in[23:0];
         s2_sqx_ff    <= sqx_in[19:0];
         s2_sqy_ff    <= sqy_in[17:0];
         s3_tag_ff    <= s2_tag_ff;
         s3_colour_ff <= 26'(s2_sql_ff) + 26'(s2_sqa_ff) + 26'(s2_sqb_ff);
         s3_space_ff  <= 21'(s2_sqx_ff) + 21'(s2_sqy_ff);
         s4_tag_ff    <= s3_tag_ff;
         s4_cm_ff     <= 34'(s3_colour_ff) * 34'(compact_ff);
         s4_space_ff  <= s3_space_ff;
         s5_tag_ff    <= s4_tag_ff;
         s5_y_ff      <= y_in;
         s5_w_ff      <= w_in;
         s5_ph_ff     <= 44'(y_in[31:16]) * 44'(COLOUR_RECIP);
         s5_pl_ff     <= 44'(y_in[15:0]) * 44'(COLOUR_RECIP);
         s5_ps_ff     <= 42'(w_in) * 42'(SPACE_RECIP);
         s5_sp230_ff  <= 29'(s4_space_ff) * 29'(SPACE_WHOLE);
         s6_tag_ff    <= s5_tag_ff;
         s6_y_ff      <= s5_y_ff;
         s6_w_ff      <= s5_w_ff;
         s6_qc_ff     <= qsum_in[59:32];
         s6_qs_ff     <= s5_ps_ff[41:22];
         s6_sp230_ff  <= s5_sp230_ff;
         s7_tag_ff    <= s6_tag_ff;
         s7_ct_ff     <= ct_in;
         s7_st_ff     <= st_in;
         s8_tag_ff    <= s7_tag_ff;
         s8_d_ff      <= 30'(s7_ct_ff) + 30'(s7_st_ff);
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   // Per-pixel memory: distance in the upper bits, label in the lower.
   logic [MemW-1:0]  mem [PixCount];
   logic [MemW-1:0]  rd_ff;
   logic             lw_valid_ff;
   logic [AddrW-1:0] lw_addr_ff;
   logic [MemW-1:0]  lw_data_ff;
   logic             mem_wr;
   logic [MemW-1:0]  new_entry;

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_cnt_ff] <= {EMPTY_DIST, EMPTY_LABEL};
      end else if (mem_wr) begin
         mem[s8_tag_ff.addr] <= new_entry;
      end
      if (en) begin
         rd_ff <= mem[s7_tag_ff.addr];
      end
   end

   // Clearing sweep after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == AddrW'(PixCount - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Compare against the stored best. The read in the same cycle as the
   // previous write sees the old entry, so that write is forwarded.
   logic               lw_hit;
   logic [MemW-1:0]    old_entry;
   logic [DIST_W-1:0]  old_d, new_d;
   logic [LABEL_W-1:0] old_l, new_l;
   logic               take;
   rsp_type            pipe_rsp;

   always_comb begin
      lw_hit = lw_valid_ff && (lw_addr_ff == s8_tag_ff.addr);
      if (s8_tag_ff.fresh) begin
         old_entry = {EMPTY_DIST, EMPTY_LABEL};
      end else if (lw_hit) begin
         old_entry = lw_data_ff;
      end else begin
         old_entry = rd_ff;
      end
      old_d     = old_entry[MemW-1:LABEL_W];
      old_l     = old_entry[LABEL_W-1:0];
      take      = s8_tag_ff.idx_ok && ({2'b00, s8_d_ff} < old_d);
      new_d     = take ? {2'b00, s8_d_ff} : old_d;
      new_l     = take ? LABEL_W'(s8_tag_ff.idx) : old_l;
      new_entry = {new_d, new_l};
      mem_wr    = en && s8_valid_ff && s8_tag_ff.in_img;

      pipe_rsp.out_x    = s8_tag_ff.px;
      pipe_rsp.out_y    = s8_tag_ff.py;
      pipe_rsp.label    = s8_tag_ff.in_img ? new_l : EMPTY_LABEL;
      pipe_rsp.distance = s8_tag_ff.in_img ? new_d : EMPTY_DIST;
      pipe_rsp.taken    = s8_tag_ff.in_img && take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (en) begin
         lw_valid_ff <= mem_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lw_addr_ff <= s8_tag_ff.addr;
         lw_data_ff <= new_entry;
      end
   end

   // Output register with one skid entry behind it.
   logic    out_valid_in, skid_valid_in;
   rsp_type out_data_in, skid_data_in;
   rsp_type out_data_ff, skid_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = s8_valid_ff;
         out_data_in  = pipe_rsp;
      end else if (s8_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A waiting skid entry always sits behind a waiting response.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid)
      else $error("skid entry held without a response in the output register");

   // The skid entry fills only when the response was stalled.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid && rsp_stall))
      else $error("skid entry filled without a stalled response");

   // The pipeline holds while the skid entry is occupied.
   a_hold_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> ($stable(s8_valid_ff) && $stable(s8_d_ff)))
      else $error("pipeline moved while the skid entry was occupied");

   // No request writes the memory during the clearing sweep.
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !mem_wr)
      else $error("memory write from a request during the clearing sweep");

   // A winning centre has a valid index and a real distance.
   a_taken_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.taken) |->
      ((32'(rsp_data.label) < 32'(MAX_CLUSTERS)) && (rsp_data.distance != EMPTY_DIST)))
      else $error("taken response with a bad label or an empty distance");

endmodule

### sim/slic_pixel_assignment_core_tb.sv
`timescale 1ns / 1ps

module slic_pixel_assignment_core_tb;
   import slicpa_pkg::*;

   localparam int RANDOM_ITEMS   = 430;
   localparam int PHASES         = 5;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 1_600_000;
   localparam int POOL_SIZE      = 24;

   // Mirrors the per-pixel distance and label memories and queues the expected responses.
   class slic_assign_board;
      logic [CMP_W-1:0]   compactness;
      logic [DIST_W-1:0]  best_dist [int unsigned];
      logic [LABEL_W-1:0] best_label [int unsigned];
      rsp_type            expected_q [$];
      int                 failures;
      int                 requests;
      int                 responses;
      int                 wins;
      int                 fresh;

      function new();
         compactness = COMPACT_RESET;
      endfunction

      // Squared difference of a pixel byte scaled to 4 fraction bits and a centre value.
      function longint unsigned colour_sq(longint pix, longint centre);
         longint d;
         d = pix * 16 - centre;
         return longint'(d * d);
      endfunction

      function longint unsigned offset_sq(longint a, longint b);
         longint d;
         d = a - b;
         return longint'(d * d);
      endfunction

      // Works out the response to an accepted request and updates the memories.
      function void note_request(req_type r);
         rsp_type            e;
         int unsigned        addr;
         longint unsigned    colour;
         longint unsigned    spatial;
         longint unsigned    total;
         logic [DIST_W-1:0]  old_d;
         logic [LABEL_W-1:0] old_l;
         logic               win;
         requests++;
         if (r.new_frame) fresh++;
         e.out_x    = r.pixel_x;
         e.out_y    = r.pixel_y;
         e.label    = EMPTY_LABEL;
         e.distance = EMPTY_DIST;
         e.taken    = 1'b0;
         if (int'(r.pixel_x) < ImageWidthDef && int'(r.pixel_y) < ImageHeightDef) begin
            addr = int'(r.pixel_y) * ImageWidthDef + int'(r.pixel_x);
            colour = colour_sq(r.pixel_l, r.center_l) + colour_sq(r.pixel_a, r.center_a)
                     + colour_sq(r.pixel_b, r.center_b);
            colour = colour * compactness / 100;
            spatial = offset_sq(r.pixel_x, r.center_x) + offset_sq(r.pixel_y, r.center_y);
            spatial = spatial * 2304 / 10;
            total = colour + spatial;
            if (total > EMPTY_DIST) total = EMPTY_DIST;
            // An entry never written, or one reopened by a new frame, counts as empty.
            if (r.new_frame || !best_dist.exists(addr)) begin
               old_d = EMPTY_DIST;
               old_l = EMPTY_LABEL;
            end else begin
               old_d = best_dist[addr];
               old_l = best_label[addr];
            end
            win = (int'(r.cluster_index) < MaxClustersDef) && (total < old_d);
            e.distance = win ? DIST_W'(total) : old_d;
            e.label    = win ? LABEL_W'(r.cluster_index) : old_l;
            e.taken    = win;
            best_dist[addr]  = e.distance;
            best_label[addr] = e.label;
            if (win) wins++;
         end
         expected_q.insert(expected_q.size(), e);
      endfunction

      // Compares an accepted response with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         responses++;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: response with none expected: x %0d y %0d label %0d dist %h taken %b",
                        $time, got.out_x, got.out_y, got.label, got.distance, got.taken);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y || got.label !== want.label
             || got.distance !== want.distance || got.taken !== want.taken) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: mismatch, expected x %0d y %0d label %0d dist %h taken %b",
                        $time, want.out_x, want.out_y, want.label, want.distance, want.taken);
               $display("%0t:           actual   x %0d y %0d label %0d dist %h taken %b",
                        $time, got.out_x, got.out_y, got.label, got.distance, got.taken);
            end
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   slic_assign_board board;
   int               send_gap_max = 14;
   int               rsp_hold_max = 14;
   int               rsp_hold     = 0;
   int               idle_cycles  = 0;
   int               pool_x [POOL_SIZE];
   int               pool_y [POOL_SIZE];
   logic [CMP_W-1:0] settings [4];

   slic_pixel_assignment_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Notes every accepted request and ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing accepted for %0d cycles.", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Checks responses and stalls the result channel for a random count after each one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_response(rsp_data);
            if ($urandom_range(0, 39) == 0) rsp_hold_max = $urandom_range(0, 1) ? 14 : 0;
            rsp_hold = $urandom_range(0, rsp_hold_max);
         end
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0) rsp_hold--;
      end
   end

   function automatic req_type make_pair(int idx, int cl, int ca, int cb, int cx, int cy,
                                         int px, int py, int pl, int pa, int pb, bit nf);
      req_type r;
      r.cluster_index = IDX_W'(idx);
      r.center_l      = LAB_C_W'(cl);
      r.center_a      = LAB_C_W'(ca);
      r.center_b      = LAB_C_W'(cb);
      r.center_x      = X_W'(cx);
      r.center_y      = Y_W'(cy);
      r.pixel_x       = X_W'(px);
      r.pixel_y       = Y_W'(py);
      r.pixel_l       = PIX_W'(pl);
      r.pixel_a       = PIX_W'(pa);
      r.pixel_b       = PIX_W'(pb);
      r.new_frame     = nf;
      return r;
   endfunction

   // A value within a spread of a base, kept inside 0 .. top.
   function automatic int near_value(int base, int spread, int top);
      int v;
      v = base + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   // Presents one request after a random gap and holds it until it is accepted.
   task automatic send_request(input req_type r);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds requests back until every response has come and the pipeline has emptied.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_compactness(input logic [CMP_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({CSR_COMPACTNESS, 2'b00});
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.compactness = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Runs of requests that test several centres against one pixel, as a window scan would.
   task automatic run_random(input int target);
      int      sent;
      int      count;
      int      k;
      int      px;
      int      py;
      int      pl;
      int      pa;
      int      pb;
      bit      nf;
      bit      opens_frame;
      req_type r;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 9) == 0) send_gap_max = $urandom_range(0, 1) ? 14 : 0;
         if ($urandom_range(0, 4) != 0) begin
            k  = $urandom_range(0, POOL_SIZE - 1);
            px = pool_x[k];
            py = pool_y[k];
         end else begin
            px = $urandom_range(0, ImageWidthDef - 1);
            py = $urandom_range(0, ImageHeightDef - 1);
         end
         pl = $urandom_range(0, 255);
         pa = $urandom_range(0, 255);
         pb = $urandom_range(0, 255);
         opens_frame = ($urandom_range(0, 2) == 0);
         count = $urandom_range(1, 6);
         for (int i = 0; i < count; i++) begin
            nf = (i == 0) ? opens_frame : ($urandom_range(0, 19) == 0);
            // Mostly nearby centres of similar colour; now and then one from anywhere.
            if ($urandom_range(0, 3) != 0)
               r = make_pair($urandom_range(0, MaxClustersDef - 1),
                             near_value(pl * 16, 64, 4095), near_value(pa * 16, 64, 4095),
                             near_value(pb * 16, 64, 4095),
                             near_value(px, 20, ImageWidthDef - 1),
                             near_value(py, 20, ImageHeightDef - 1),
                             px, py, pl, pa, pb, nf);
            else
               r = make_pair($urandom_range(0, MaxClustersDef - 1), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, ImageWidthDef - 1),
                             $urandom_range(0, ImageHeightDef - 1),
                             px, py, pl, pa, pb, nf);
            send_request(r);
            sent++;
         end
      end
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Pixels revisited often: the four corners and a few random spots.
      pool_x[0] = 0;                 pool_y[0] = 0;
      pool_x[1] = ImageWidthDef - 1; pool_y[1] = ImageHeightDef - 1;
      pool_x[2] = 0;                 pool_y[2] = ImageHeightDef - 1;
      pool_x[3] = ImageWidthDef - 1; pool_y[3] = 0;
      for (int i = 4; i < POOL_SIZE; i++) begin
         pool_x[i] = $urandom_range(0, ImageWidthDef - 1);
         pool_y[i] = $urandom_range(0, ImageHeightDef - 1);
      end
      settings[0] = 8'd0;
      settings[1] = 8'd1;
      settings[2] = 8'd255;
      settings[3] = CMP_W'($urandom_range(2, 254));

      // Directed requests at the reset compactness: exact match, a tie, wins and losses,
      // a new frame taking a worse centre, sub-unit colour error and all-ones fields.
      send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_request(make_pair(5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_pair(4095, 0, 0, 0, 0, 0, 1023, 511, 255, 255, 255, 0));
      send_request(make_pair(7, 4095, 4095, 4095, 1023, 511, 1023, 511, 255, 255, 255, 0));
      send_request(make_pair(9, 2048, 2048, 2048, 1000, 500, 1023, 511, 255, 255, 255, 0));
      send_request(make_pair(9, 2048, 2048, 2048, 1000, 500, 1023, 511, 255, 255, 255, 1));
      send_request(make_pair(100, 1601, 1599, 1600, 512, 256, 512, 256, 100, 100, 100, 0));
      send_request(make_pair(3, 16, 16, 16, 0, 0, 3, 4, 1, 1, 1, 0));
      send_request(make_pair(1, 0, 0, 0, 12, 10, 10, 10, 0, 0, 0, 0));
      send_request(make_pair(2, 0, 0, 0, 8, 10, 10, 10, 0, 0, 0, 0));
      send_request(make_pair(4095, 4095, 4095, 4095, 1023, 511, 1023, 511, 255, 255, 255, 1));
      send_request(make_pair(2730, 2730, 1365, 2730, 682, 341, 341, 170, 170, 85, 170, 0));
      send_request(make_pair(1365, 1365, 2730, 1365, 341, 170, 682, 341, 85, 170, 85, 1));
      send_request(make_pair(0, 4095, 0, 4095, 0, 511, 1023, 0, 0, 255, 0, 0));
      run_random(RANDOM_ITEMS / PHASES);

      // Further phases at zero, one, maximum and one random compactness.
      foreach (settings[s]) begin
         wait_drained();
         write_compactness(settings[s]);
         run_random(RANDOM_ITEMS / PHASES);
      end
      wait_drained();

      $display("Covered %0d requests at compactness 10, 0, 1, 255 and %0d; %0d responses checked.",
               board.requests, settings[3], board.responses);
      $display("%0d centres replaced the best distance; %0d requests opened a new frame.",
               board.wins, board.fresh);
      if (board.failures == 0 && board.expected_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
rtl/slicpa_pkg.sv
rtl/slic_pixel_assignment_core.sv
sim/slic_pixel_assignment_core_tb.sv
